/* src/sspg_pkg.sv */
package sspg_pkg;

    // command codes
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_GRAB  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_HALF_BIT   = 2'd0;
    localparam logic [1:0] REG_TURNAROUND = 2'd1;
    localparam logic [1:0] REG_GAP        = 2'd2;
    localparam logic [1:0] REG_POLL_LIMIT = 2'd3;

    localparam logic [15:0] HALF_BIT_RESET   = 16'd180;
    localparam logic [15:0] TURNAROUND_RESET = 16'd7920;
    localparam logic [15:0] GAP_RESET        = 16'd7920;
    localparam logic [15:0] POLL_LIMIT_RESET = 16'd10000;

    localparam logic [8:0]  PIXEL_MAX      = 9'd324;
    localparam logic [7:0]  WRITE_FLAG     = 8'h80;
    localparam logic [7:0]  PIXEL_REG      = 8'h08;
    localparam logic [7:0]  GRAB_WORD      = 8'h2A;
    localparam logic [7:0]  PIXEL_MASK     = 8'hBF;
    localparam int          PIXEL_FLAG_BIT = 6;

    typedef struct packed {
        logic [1:0] command;
        logic [6:0] reg_address;
        logic [7:0] reg_data;
        logic [8:0] pixel_count;
        logic       sdio_in;
    } item_t;

    typedef struct packed {
        logic        sck;
        logic        sdio_out;
        logic        sdio_drive;
        logic        busy_res;
        logic        read_valid;
        logic [7:0]  read_data;
        logic        pixel_valid;
        logic [7:0]  pixel_value;
        logic        pixel_last;
        logic [15:0] lost_count;
        logic        timed_out;
    } result_t;

    typedef struct packed {
        logic [15:0] half_bit_ticks;
        logic [15:0] turnaround_ticks;
        logic [15:0] gap_ticks;
        logic [15:0] poll_limit;
    } cfg_t;

endpackage

/* src/sspg_seq.sv */
module sspg_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  sspg_pkg::item_t  item,
    input  sspg_pkg::cfg_t   cfg,
    output sspg_pkg::result_t result
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SEND_LO,
        PH_SEND_HI,
        PH_TURN,
        PH_RECV_LO,
        PH_RECV_HI,
        PH_GAP
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  operation_reg, operation_next;
    logic [15:0] tick_count_reg, tick_count_next;
    logic [2:0]  bit_index_reg, bit_index_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic        second_byte_reg, second_byte_next;
    logic [8:0]  pixels_taken_reg, pixels_taken_next;
    logic [8:0]  pixels_wanted_reg, pixels_wanted_next;
    logic [15:0] polls_done_reg, polls_done_next;
    logic [15:0] lost_total_reg, lost_total_next;
    logic [7:0]  data_latch_reg, data_latch_next;
    logic        line_level_reg, line_level_next;

    always_comb
    begin
        logic [15:0] tick_inc;
        logic [15:0] len;
        logic        done;
        logic        in_read;
        logic [8:0]  taken_inc;
        logic        finished;

        phase_next         = phase_reg;
        operation_next     = operation_reg;
        tick_count_next    = tick_count_reg;
        bit_index_next     = bit_index_reg;
        shift_byte_next    = shift_byte_reg;
        second_byte_next   = second_byte_reg;
        pixels_taken_next  = pixels_taken_reg;
        pixels_wanted_next = pixels_wanted_reg;
        polls_done_next    = polls_done_reg;
        lost_total_next    = lost_total_reg;
        data_latch_next    = data_latch_reg;
        line_level_next    = line_level_reg;
        result             = '0;
        result.sck         = 1'b1;
        result.sdio_drive  = 1'b1;
        finished           = 1'b0;
        taken_inc          = pixels_taken_reg + 9'd1;

        // take a new command only from idle
        if (phase_reg == PH_IDLE && item.command != sspg_pkg::CMD_NONE)
        begin
            operation_next   = item.command;
            tick_count_next  = '0;
            second_byte_next = 1'b0;
            bit_index_next   = '0;
            phase_next       = PH_SEND_LO;
            unique case (item.command)
                sspg_pkg::CMD_WRITE:
                begin
                    data_latch_next = item.reg_data;
                    shift_byte_next = {1'b0, item.reg_address} | sspg_pkg::WRITE_FLAG;
                end
                sspg_pkg::CMD_READ:
                begin
                    shift_byte_next = {1'b0, item.reg_address};
                end
                default:
                begin
                    pixels_wanted_next = (item.pixel_count > sspg_pkg::PIXEL_MAX)
                                         ? sspg_pkg::PIXEL_MAX : item.pixel_count;
                    pixels_taken_next  = '0;
                    polls_done_next    = '0;
                    lost_total_next    = '0;
                    data_latch_next    = sspg_pkg::GRAB_WORD;
                    shift_byte_next    = sspg_pkg::PIXEL_REG | sspg_pkg::WRITE_FLAG;
                end
            endcase
        end

        result.busy_res = (phase_next != PH_IDLE);
        unique case (phase_next)
            PH_SEND_LO:
            begin
                result.sck      = 1'b0;
                line_level_next = shift_byte_next[3'd7 - bit_index_next];
            end
            PH_RECV_LO:
            begin
                result.sck        = 1'b0;
                result.sdio_drive = 1'b0;
            end
            PH_RECV_HI, PH_TURN:
            begin
                result.sdio_drive = 1'b0;
            end
            default:
            begin
            end
        endcase
        result.sdio_out = line_level_next;

        unique case (phase_next)
            PH_TURN: len = cfg.turnaround_ticks;
            PH_GAP:  len = cfg.gap_ticks;
            default: len = cfg.half_bit_ticks;
        endcase
        if (len == 16'd0)
        begin
            len = 16'd1;
        end
        tick_inc = tick_count_next + 16'd1;
        done     = (tick_inc >= len);
        in_read  = (operation_next == sspg_pkg::CMD_READ)
                || (operation_next == sspg_pkg::CMD_GRAB && polls_done_next != 16'd0);
        taken_inc = pixels_taken_next + 9'd1;

        if (phase_next != PH_IDLE)
        begin
            tick_count_next = done ? 16'd0 : tick_inc;
            if (done)
            begin
                unique case (phase_next)
                    PH_SEND_LO:
                    begin
                        phase_next = PH_SEND_HI;
                    end
                    PH_SEND_HI:
                    begin
                        if (bit_index_next != 3'd7)
                        begin
                            bit_index_next = bit_index_next + 3'd1;
                            phase_next     = PH_SEND_LO;
                        end
                        else if (in_read)
                        begin
                            bit_index_next = '0;
                            phase_next     = PH_TURN;
                        end
                        else if (!second_byte_next)
                        begin
                            second_byte_next = 1'b1;
                            shift_byte_next  = data_latch_next;
                            bit_index_next   = '0;
                            phase_next       = PH_SEND_LO;
                        end
                        else
                        begin
                            bit_index_next = '0;
                            phase_next     = PH_GAP;
                        end
                    end
                    PH_TURN:
                    begin
                        shift_byte_next = '0;
                        bit_index_next  = '0;
                        phase_next      = PH_RECV_LO;
                    end
                    PH_RECV_LO:
                    begin
                        shift_byte_next = {shift_byte_next[6:0], item.sdio_in};
                        phase_next      = PH_RECV_HI;
                    end
                    PH_RECV_HI:
                    begin
                        if (bit_index_next != 3'd7)
                        begin
                            bit_index_next = bit_index_next + 3'd1;
                            phase_next     = PH_RECV_LO;
                        end
                        else if (operation_next == sspg_pkg::CMD_READ)
                        begin
                            result.read_valid = 1'b1;
                            result.read_data  = shift_byte_next;
                            phase_next        = PH_IDLE;
                        end
                        else
                        begin
                            if (!shift_byte_next[sspg_pkg::PIXEL_FLAG_BIT])
                            begin
                                if (lost_total_next != 16'hFFFF)
                                begin
                                    lost_total_next = lost_total_next + 16'd1;
                                end
                            end
                            else
                            begin
                                result.pixel_valid = 1'b1;
                                result.pixel_value = shift_byte_next & sspg_pkg::PIXEL_MASK;
                                pixels_taken_next  = taken_inc;
                                if (taken_inc >= pixels_wanted_next)
                                begin
                                    result.pixel_last = 1'b1;
                                    finished          = 1'b1;
                                end
                            end
                            if (finished)
                            begin
                                phase_next = PH_IDLE;
                            end
                            else if (polls_done_next >= cfg.poll_limit)
                            begin
                                result.timed_out = 1'b1;
                                phase_next       = PH_IDLE;
                            end
                            else
                            begin
                                if (polls_done_next != 16'hFFFF)
                                begin
                                    polls_done_next = polls_done_next + 16'd1;
                                end
                                shift_byte_next = sspg_pkg::PIXEL_REG;
                                bit_index_next  = '0;
                                phase_next      = PH_SEND_LO;
                            end
                        end
                    end
                    PH_GAP:
                    begin
                        if (operation_next == sspg_pkg::CMD_GRAB && pixels_wanted_next != 9'd0)
                        begin
                            if (polls_done_next != 16'hFFFF)
                            begin
                                polls_done_next = polls_done_next + 16'd1;
                            end
                            shift_byte_next = sspg_pkg::PIXEL_REG;
                            bit_index_next  = '0;
                            phase_next      = PH_SEND_LO;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
        result.lost_count = lost_total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            operation_reg     <= '0;
            tick_count_reg    <= '0;
            bit_index_reg     <= '0;
            shift_byte_reg    <= '0;
            second_byte_reg   <= 1'b0;
            pixels_taken_reg  <= '0;
            pixels_wanted_reg <= '0;
            polls_done_reg    <= '0;
            lost_total_reg    <= '0;
            data_latch_reg    <= '0;
            line_level_reg    <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg         <= phase_next;
            operation_reg     <= operation_next;
            tick_count_reg    <= tick_count_next;
            bit_index_reg     <= bit_index_next;
            shift_byte_reg    <= shift_byte_next;
            second_byte_reg   <= second_byte_next;
            pixels_taken_reg  <= pixels_taken_next;
            pixels_wanted_reg <= pixels_wanted_next;
            polls_done_reg    <= polls_done_next;
            lost_total_reg    <= lost_total_next;
            data_latch_reg    <= data_latch_next;
            line_level_reg    <= line_level_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (tick_count_reg == 16'd0))
        else $error("tick counter running while idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (operation_reg != sspg_pkg::CMD_GRAB) |-> !result.pixel_valid)
        else $error("pixel beat outside a grab");

    assert property (@(posedge clk) disable iff (!rst_n)
        (pixels_taken_reg <= pixels_wanted_reg))
        else $error("more pixels taken than wanted");

endmodule

/* src/sensor_serial_pixel_grabber.sv */
// channel | valid     | stall     | payload
// --------+-----------+-----------+----------------------------------------
// cmd     | cmd_valid | cmd_stall | cmd (sspg_pkg::item_t), one tick a beat
// res     | res_valid | res_stall | res (sspg_pkg::result_t), one per tick
// cfg     | cfg_write | -         | cfg_index, cfg_data (16 bits)
//
// Each accepted cmd beat is one tick of the pin sequencer; its result beat
// shows in the output register on the next cycle, so one beat per cycle while cmd_stall is low.
// The tick logic sits between the sequencer state and the result register.
// cmd_stall rises only while a result is held and res_stall is high.
// Reset clears the sequencer to idle and loads the register defaults.
module sensor_serial_pixel_grabber (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  sspg_pkg::item_t   cmd,
    output logic              res_valid,
    input  logic              res_stall,
    output sspg_pkg::result_t res,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data
);

    sspg_pkg::cfg_t    cfg_reg;
    sspg_pkg::result_t tick_result;
    sspg_pkg::result_t res_reg;
    logic              res_valid_reg;
    logic              accept;

    assign cmd_stall = res_valid_reg && res_stall;
    assign accept    = cmd_valid && !cmd_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    sspg_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .item    (cmd),
        .cfg     (cfg_reg),
        .result  (tick_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_bit_ticks   <= sspg_pkg::HALF_BIT_RESET;
            cfg_reg.turnaround_ticks <= sspg_pkg::TURNAROUND_RESET;
            cfg_reg.gap_ticks        <= sspg_pkg::GAP_RESET;
            cfg_reg.poll_limit       <= sspg_pkg::POLL_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sspg_pkg::REG_HALF_BIT:   cfg_reg.half_bit_ticks   <= cfg_data;
                sspg_pkg::REG_TURNAROUND: cfg_reg.turnaround_ticks <= cfg_data;
                sspg_pkg::REG_GAP:        cfg_reg.gap_ticks        <= cfg_data;
                sspg_pkg::REG_POLL_LIMIT: cfg_reg.poll_limit       <= cfg_data;
                default:                  cfg_reg.poll_limit       <= cfg_data;
            endcase
        end
    end

    // hold the result beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= tick_result;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> res_valid)
        else $error("accepted beat produced no result");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res.read_valid && res.pixel_valid))
        else $error("read and pixel in one beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.pixel_last |-> res.pixel_valid)
        else $error("last flag without pixel");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.sdio_drive |-> res.busy_res)
        else $error("line released while idle");

endmodule
